// ===== rtl/core/obb_pkg.sv =====
// obb_pkg: shared types, constants and the arctangent table for the obb block
// used by obb_cordic_cell, obb_corner_unit and obb_corners_and_bounds
`timescale 1ns / 1ps
package obb_pkg;
  localparam int COORD_BITS = 32;
  localparam int ANGLE_BITS = 16;
  localparam int TRIG_FRAC = ((62 - COORD_BITS) < 30) ? (62 - COORD_BITS) : 30;
  localparam int CORDIC_STEPS = 30;
  localparam int CW = 33;  // cordic datapath width, q2.30 plus guard
  localparam int ZW = 32;
  localparam int TW = TRIG_FRAC + 2;
  localparam logic signed [CW-1:0] GAIN_INV = CW'(652032874);
  localparam logic signed [CW-1:0] ONE_Q30 = CW'(64'sd1 << 30);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-2:0] size_x;
    logic [COORD_BITS-2:0] size_y;
    logic [ANGLE_BITS-1:0] angle;
  } obb_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] corner0_x;
    logic signed [COORD_BITS-1:0] corner0_y;
    logic signed [COORD_BITS-1:0] corner1_x;
    logic signed [COORD_BITS-1:0] corner1_y;
    logic signed [COORD_BITS-1:0] corner2_x;
    logic signed [COORD_BITS-1:0] corner2_y;
    logic signed [COORD_BITS-1:0] corner3_x;
    logic signed [COORD_BITS-1:0] corner3_y;
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] max_y;
  } obb_out_t;

  // word carried along the cell chain
  typedef struct packed {
    logic valid;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0] quad;
    logic exact;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [COORD_BITS-2:0] sx;
    logic [COORD_BITS-2:0] sy;
  } obb_cell_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0: r = 536870912;  5'd1: r = 316933406;  5'd2: r = 167458907;
      5'd3: r = 85004756;   5'd4: r = 42667331;   5'd5: r = 21354465;
      5'd6: r = 10679838;   5'd7: r = 5340245;    5'd8: r = 2670163;
      5'd9: r = 1335087;    5'd10: r = 667544;    5'd11: r = 333772;
      5'd12: r = 166886;    5'd13: r = 83443;     5'd14: r = 41722;
      5'd15: r = 20861;     5'd16: r = 10430;     5'd17: r = 5215;
      5'd18: r = 2608;      5'd19: r = 1304;      5'd20: r = 652;
      5'd21: r = 326;       5'd22: r = 163;       5'd23: r = 81;
      5'd24: r = 41;        5'd25: r = 20;        5'd26: r = 10;
      5'd27: r = 5;         5'd28: r = 3;         5'd29: r = 1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ===== rtl/core/obb_cordic_cell.sv =====
// obb_cordic_cell: one cordic micro-rotation stage of the chain
// depends on obb_pkg
`timescale 1ns / 1ps
module obb_cordic_cell
  import obb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [4:0] step,
  input  obb_cell_t  cell_in,
  output obb_cell_t  cell_out
);
  obb_cell_t cell_r, cell_nxt;
  logic signed [CW-1:0] dx, dy;

  always_comb begin
    cell_nxt = cell_in;
    dx = cell_in.y >>> step;
    dy = cell_in.x >>> step;
    if (!cell_in.exact) begin
      if (cell_in.z >= 0) begin
        cell_nxt.x = cell_in.x - dx;
        cell_nxt.y = cell_in.y + dy;
        cell_nxt.z = cell_in.z - atan_lut(step);
      end else begin
        cell_nxt.x = cell_in.x + dx;
        cell_nxt.y = cell_in.y - dy;
        cell_nxt.z = cell_in.z + atan_lut(step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;
endmodule

// ===== rtl/core/obb_corner_unit.sv =====
// obb_corner_unit: products, rounding, centre add and saturation for one corner
// depends on obb_pkg
`timescale 1ns / 1ps
module obb_corner_unit
  import obb_pkg::*;
(
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS:0]   lx,
  input  logic signed [COORD_BITS:0]   ly,
  input  logic signed [TW-1:0]         cs,
  input  logic signed [TW-1:0]         sn,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  output logic signed [COORD_BITS-1:0] px,
  output logic signed [COORD_BITS-1:0] py
);
  localparam int PW = COORD_BITS + TW + 2;
  localparam int SW = PW - TRIG_FRAC;
  localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);
  logic signed [PW-1:0] lxc_r, lys_r, lxs_r, lyc_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic signed [PW-1:0] rx, ry;
  logic signed [SW-1:0] sx_w, sy_w;

  always_ff @(posedge clk) begin
    if (en) begin
      lxc_r <= PW'(lx) * PW'(cs);
      lys_r <= PW'(ly) * PW'(sn);
      lxs_r <= PW'(lx) * PW'(sn);
      lyc_r <= PW'(ly) * PW'(cs);
      cx_r <= cx;
      cy_r <= cy;
    end
  end

  always_comb begin
    rx = lxc_r - lys_r + (PW'(1) <<< TRIG_FRAC);
    ry = lxs_r + lyc_r + (PW'(1) <<< TRIG_FRAC);
    sx_w = SW'(rx >>> (TRIG_FRAC + 1)) + SW'(cx_r);
    sy_w = SW'(ry >>> (TRIG_FRAC + 1)) + SW'(cy_r);
    px = (sx_w > CMAX) ? CMAX[COORD_BITS-1:0] :
         (sx_w < CMIN) ? CMIN[COORD_BITS-1:0] : sx_w[COORD_BITS-1:0];
    py = (sy_w > CMAX) ? CMAX[COORD_BITS-1:0] :
         (sy_w < CMIN) ? CMIN[COORD_BITS-1:0] : sy_w[COORD_BITS-1:0];
  end
endmodule

// ===== rtl/core/obb_corners_and_bounds.sv =====
// obb_corners_and_bounds: oriented box to four world corners and bounding box
// depends on obb_pkg, obb_cordic_cell and obb_corner_unit
`timescale 1ns / 1ps
// usage
//   in_valid/in_ready/in_data carry one box word: centre, full size, angle
//   out_valid/out_ready/out_data carry the four corners and the min/max bounds
//   one result word for every box word, in order
// pipeline
//   one entry register, 30 cordic cells, one trig register, one product
//   register, one bounds register: 34 register stages; the entry register
//   loads at the accepting edge
// throughput
//   one box per cycle unless stalled; each cell passes its word on each cycle
// stall
//   the whole chain advances only when the output register is free or being
//   taken, so in_ready = out_ready or output empty; nothing is dropped
// reset
//   synchronous active-low rst_n clears every valid bit; payload is not reset
module obb_corners_and_bounds
  import obb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  obb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output obb_out_t out_data
);
  localparam int NST = CORDIC_STEPS;

  logic en;
  obb_cell_t chain [0:NST];
  obb_cell_t entry_r, entry_nxt;

  // trig stage
  logic signed [TW-1:0] cs_r, sn_r;
  logic signed [CW-1:0] c_raw, s_raw;
  logic signed [TW-1:0] cs_nxt, sn_nxt;
  logic trig_v_r;
  logic signed [COORD_BITS-1:0] tcx_r, tcy_r;
  logic [COORD_BITS-2:0] tsx_r, tsy_r;

  // product stage
  logic prod_v_r;
  logic signed [COORD_BITS-1:0] px [0:3];
  logic signed [COORD_BITS-1:0] py [0:3];

  logic out_v_r;
  obb_out_t out_r;
  logic signed [COORD_BITS-1:0] lo_x, lo_y, hi_x, hi_y;

  assign en = !out_v_r || out_ready;
  assign in_ready = en;
  assign out_valid = out_v_r;
  assign out_data = out_r;

  // entry: phase split into quadrant and residual angle
  always_comb begin
    logic [31:0] phase;
    phase = 32'(in_data.angle) << (32 - ANGLE_BITS);
    entry_nxt.valid = in_valid;
    entry_nxt.quad = phase[31:30];
    entry_nxt.z = ZW'({2'b00, phase[29:0]});
    entry_nxt.exact = (phase[29:0] == '0);
    entry_nxt.x = (phase[29:0] == '0) ? ONE_Q30 : GAIN_INV;
    entry_nxt.y = '0;
    entry_nxt.cx = in_data.center_x;
    entry_nxt.cy = in_data.center_y;
    entry_nxt.sx = in_data.size_x;
    entry_nxt.sy = in_data.size_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (en) begin
      entry_r <= entry_nxt;
    end
  end

  assign chain[0] = entry_r;

  genvar g;
  generate
    for (g = 0; g < NST; g++) begin : g_cell
      obb_cordic_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .step    (5'(g)),
        .cell_in (chain[g]),
        .cell_out(chain[g+1])
      );
    end
  endgenerate

  // quadrant fold, clamp and round to trig precision
  function automatic logic signed [TW-1:0] to_trig(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] c;
    logic signed [CW:0] r;
    c = (v > ONE_Q30) ? ONE_Q30 : ((v < -ONE_Q30) ? -ONE_Q30 : v);
    if (TRIG_FRAC == 30) begin
      r = (CW+1)'(c);
    end else begin
      r = ((CW+1)'(c) + ((CW+1)'(1) <<< (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC);
    end
    return TW'(r);
  endfunction

  always_comb begin
    unique case (chain[NST].quad)
      2'd0: begin c_raw = chain[NST].x;  s_raw = chain[NST].y;  end
      2'd1: begin c_raw = -chain[NST].y; s_raw = chain[NST].x;  end
      2'd2: begin c_raw = -chain[NST].x; s_raw = -chain[NST].y; end
      default: begin c_raw = chain[NST].y; s_raw = -chain[NST].x; end
    endcase
    cs_nxt = to_trig(c_raw);
    sn_nxt = to_trig(s_raw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_v_r <= 1'b0;
    end else if (en) begin
      trig_v_r <= chain[NST].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= cs_nxt;
      sn_r <= sn_nxt;
      tcx_r <= chain[NST].cx;
      tcy_r <= chain[NST].cy;
      tsx_r <= chain[NST].sx;
      tsy_r <= chain[NST].sy;
    end
  end

  // local corners: ccw from (-w,-h)
  logic signed [COORD_BITS:0] psx, nsx, psy, nsy;
  assign psx = (COORD_BITS+1)'({2'b00, tsx_r});
  assign psy = (COORD_BITS+1)'({2'b00, tsy_r});
  assign nsx = -psx;
  assign nsy = -psy;

  obb_corner_unit u_c0 (.clk(clk), .en(en), .lx(nsx), .ly(nsy), .cs(cs_r), .sn(sn_r),
    .cx(tcx_r), .cy(tcy_r), .px(px[0]), .py(py[0]));
  obb_corner_unit u_c1 (.clk(clk), .en(en), .lx(psx), .ly(nsy), .cs(cs_r), .sn(sn_r),
    .cx(tcx_r), .cy(tcy_r), .px(px[1]), .py(py[1]));
  obb_corner_unit u_c2 (.clk(clk), .en(en), .lx(psx), .ly(psy), .cs(cs_r), .sn(sn_r),
    .cx(tcx_r), .cy(tcy_r), .px(px[2]), .py(py[2]));
  obb_corner_unit u_c3 (.clk(clk), .en(en), .lx(nsx), .ly(psy), .cs(cs_r), .sn(sn_r),
    .cx(tcx_r), .cy(tcy_r), .px(px[3]), .py(py[3]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else if (en) begin
      prod_v_r <= trig_v_r;
    end
  end

  // bounds over the saturated corners
  always_comb begin
    lo_x = px[0]; hi_x = px[0]; lo_y = py[0]; hi_y = py[0];
    for (int k = 1; k < 4; k++) begin
      if (px[k] < lo_x) lo_x = px[k];
      if (px[k] > hi_x) hi_x = px[k];
      if (py[k] < lo_y) lo_y = py[k];
      if (py[k] > hi_y) hi_y = py[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= prod_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.corner0_x <= px[0]; out_r.corner0_y <= py[0];
      out_r.corner1_x <= px[1]; out_r.corner1_y <= py[1];
      out_r.corner2_x <= px[2]; out_r.corner2_y <= py[2];
      out_r.corner3_x <= px[3]; out_r.corner3_y <= py[3];
      out_r.min_x <= lo_x; out_r.min_y <= lo_y;
      out_r.max_x <= hi_x; out_r.max_y <= hi_y;
    end
  end

`ifndef SYNTHESIS
  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r && $stable(out_r))
    else $error("output word changed under stall");
  // bounds checked against corner0/corner2 in x and corner1/corner3 in y
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.min_x <= out_r.corner0_x && out_r.max_x >= out_r.corner2_x
      && out_r.min_y <= out_r.corner1_y && out_r.max_y >= out_r.corner3_y)
    else $error("bounds do not enclose corners");
  // trig and product valid bits frozen while stalled
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(prod_v_r) && $stable(trig_v_r))
    else $error("pipeline moved during stall");
`endif
endmodule
